// ===== hdl/bus_pkg.sv =====
package bus_pkg;

    // Set geometry
    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 32;
    localparam int OUT_CNT_W = 5;

    // Request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_ABSENT   = 3'd4
    } t_status_code;

    // Table update chosen by the controller
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_APPEND,
        ACT_SHIFT
    } t_act;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // Input word
    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } t_in_word;

    // Output word
    typedef struct packed {
        t_status_code   status;
        logic [4:0]     count;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic         load;
        logic         cmp;
        logic         upd;
        t_act         act;
        t_status_code code;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic op;
        logic full;
        logic hit;
    } t_dp_status;

endpackage

// ===== hdl/bus_datapath.sv =====
module bus_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bus_pkg::t_in_word  i_in_word,
    input  bus_pkg::t_dp_cmd   i_cmd,
    output bus_pkg::t_dp_status o_status,
    output bus_pkg::t_out_word o_out_word
);
    import bus_pkg::*;

    logic [VAL_W-1:0] r_entry [CAPACITY];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_op;
    logic [VAL_W-1:0] r_value;
    logic [CAPACITY-1:0] r_match;
    logic             r_hit;
    t_out_word        r_out;

    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_shift;

    // Per-cell compare, gated to occupied cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
        assign w_match[i] = (CNT_W'(i) < r_count) && (r_entry[i] == r_value);
        // cell shifts down when the hit sits at or below it
        assign w_shift[i] = |r_match[i:0];
    end

    // Count after the update
    always_comb begin
        case (i_cmd.act)
            ACT_APPEND: n_count = r_count + CNT_W'(1);
            ACT_SHIFT:  n_count = r_count - CNT_W'(1);
            default:    n_count = r_count;
        endcase
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.upd) begin
            r_count <= n_count;
        end
    end

    // Request capture, compare result, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_word.op;
            r_value <= i_in_word.value;
        end
        if (i_cmd.cmp) begin
            r_match <= w_match;
            r_hit   <= |w_match;
        end
        if (i_cmd.upd) begin
            r_out.status <= i_cmd.code;
            r_out.count  <= OUT_CNT_W'(n_count);
        end
    end

    // Table cells: append at the fill count or close the gap
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && i_cmd.act == ACT_APPEND) begin
            r_entry[r_count[IDX_W-1:0]] <= r_value;
        end
        if (i_cmd.upd && i_cmd.act == ACT_SHIFT) begin
            for (int j = 0; j < CAPACITY - 1; j++) begin
                if (w_shift[j]) begin
                    r_entry[j] <= r_entry[j+1];
                end
            end
        end
    end

    assign o_status.op   = r_op;
    assign o_status.full = (r_count == CNT_W'(CAPACITY));
    assign o_status.hit  = r_hit;
    assign o_out_word    = r_out;

endmodule

// ===== hdl/bus_ctrl.sv =====
module bus_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  bus_pkg::t_dp_status i_status,
    output bus_pkg::t_dp_cmd    o_cmd
);
    import bus_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_upd_ok;
    logic   w_in_take;

    // Update fires once the output register is free or being drained
    assign w_upd_ok  = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);
    assign w_in_take = i_in_valid && ((r_state == S_IDLE) || w_upd_ok);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_take) n_state = S_CMP;
            S_CMP:  n_state = S_UPD;
            S_UPD: begin
                if (w_upd_ok) n_state = w_in_take ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands and result decode
    always_comb begin
        o_cmd.load = w_in_take;
        o_cmd.cmp  = (r_state == S_CMP);
        o_cmd.upd  = w_upd_ok;
        o_cmd.act  = ACT_NONE;
        o_cmd.code = ST_ABSENT;
        unique case (i_status.op)
            OP_INSERT: begin
                if (i_status.full) begin
                    o_cmd.code = ST_FULL;
                end else if (i_status.hit) begin
                    o_cmd.code = ST_PRESENT;
                end else begin
                    o_cmd.code = ST_INSERTED;
                    o_cmd.act  = ACT_APPEND;
                end
            end
            OP_REMOVE: begin
                if (i_status.hit) begin
                    o_cmd.code = ST_REMOVED;
                    o_cmd.act  = ACT_SHIFT;
                end
            end
            default: o_cmd.act = ACT_NONE;
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = !((r_state == S_IDLE) || w_upd_ok);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/bounded_unique_set_core.sv =====
// Bounded unique set: holds up to 16 distinct 32-bit values in insertion order.
// Input channel (i_in_valid / o_in_stall / i_in_word): one request word, an
// opcode (insert or remove) and a value. Output channel (o_out_valid /
// i_out_stall / o_out_word): one result word per request, a status code and
// the element count after the request.
// The request word is registered when the request is accepted; the parallel
// compare across all cells is registered in the compare step, and the table
// update (append or compaction shift) in the update step also loads the
// output register; the update waits while a stalled result still holds.
// The controller runs the compare/update sequence for each request; the next
// request is taken in the update cycle, before the previous result is out.
// Reset (synchronous, active low) empties the set and drops any pending
// result; cell contents are not cleared and never compared above the count.
// A stalled result holds in the output register; one more request may be
// taken and compared, and it waits in the update step until the output
// register drains.
module bounded_unique_set_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bus_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bus_pkg::t_out_word o_out_word
);
    import bus_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    bus_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bus_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_word (o_out_word)
    );

endmodule

// ===== hdl/bus_checker.sv =====
module bus_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bus_pkg::t_out_word o_out_word
);
    import bus_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    // Full rejection only at capacity
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_FULL |->
        o_out_word.count == OUT_CNT_W'(CAPACITY))
        else $error("full status below capacity");

    // Insert or hit leaves a nonempty set
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_INSERTED ||
                        o_out_word.status == ST_PRESENT) |->
        o_out_word.count != '0)
        else $error("empty set after insert or hit");

    // Remove leaves room
    a_remove_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_REMOVED |->
        o_out_word.count < OUT_CNT_W'(CAPACITY))
        else $error("full set after remove");

endmodule

bind bounded_unique_set_core bus_checker u_bus_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ===== bench/bounded_unique_set_core_test.sv =====
module bounded_unique_set_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bus_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Request word waiting in the driver queue; hold makes the sender
    // wait until every outstanding result has drained before presenting it
    typedef struct {
        t_in_word word;
        bit       hold;
    } t_pend;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    t_pend       req_q[$];
    t_out_word   result_q[$];
    logic [31:0] set_vals[CAPACITY];
    int          set_len = 0;
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 8;
    int          gap_left = 0;
    int          stall_left = 0;
    int          free_left = 0;

    bounded_unique_set_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Clock and reset
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("bounded_unique_set_core_test: FAIL");
            $finish;
        end
    end

    // Applies one request to the shadow set and returns the result word
    function automatic t_out_word apply_request(t_in_word w);
        t_out_word r;
        int        slot;
        slot = -1;
        for (int i = 0; i < set_len; i++) begin
            if (slot < 0 && set_vals[i] == w.value)
                slot = i;
        end
        if (w.op == OP_INSERT) begin
            // full check wins over the duplicate check
            if (set_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else if (slot >= 0) begin
                r.status = ST_PRESENT;
            end else begin
                set_vals[set_len] = w.value;
                set_len++;
                r.status = ST_INSERTED;
            end
        end else if (slot < 0) begin
            r.status = ST_ABSENT;
        end else begin
            // close the gap
            for (int j = slot; j < set_len - 1; j++)
                set_vals[j] = set_vals[j + 1];
            set_len--;
            r.status = ST_REMOVED;
        end
        r.count = set_len[4:0];
        return r;
    endfunction

    function automatic void queue_req(logic op, logic [31:0] v, bit hold = 1'b0);
        t_pend p;
        p.word.op    = op;
        p.word.value = v;
        p.hold       = hold;
        req_q.push_back(p);
    endfunction

    // Driver: bursts of words with random gaps
    always @(posedge i_clk) begin : driver
        t_pend nxt;
        logic  fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && !o_in_stall;
            if (fire) begin
                result_q.push_back(apply_request(i_in_word));
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!i_in_valid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (req_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (req_q[0].hold && result_q.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = req_q.pop_front();
                    i_in_word  <= nxt.word;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks each result word and drives the stall pattern
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got status=%0d count=%0d",
                         $time, o_out_word.status, o_out_word.count);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (o_out_word.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_out_word.status);
                    errors++;
                end
                if (o_out_word.count !== want.count) begin
                    $display("%0t: count mismatch, expected %0d, got %0d",
                             $time, want.count, o_out_word.count);
                    errors++;
                end
            end
        end
        // stall runs, short free runs, now and then a long free stretch
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                free_left = $urandom_range(30, 80);
            end else begin
                free_left  = $urandom_range(0, 6);
                stall_left = $urandom_range(1, 9);
            end
            i_out_stall <= 1'b0;
        end
    end

    // Stimulus and end of run
    initial begin : stim
        logic [31:0] pool[24];
        int          npool;
        int          ins_pct;
        logic        op;
        logic [31:0] v;

        // remove from an empty set
        queue_req(OP_REMOVE, 32'd5);
        // field extremes
        queue_req(OP_INSERT, 32'h8000_0000);
        queue_req(OP_INSERT, 32'h7fff_ffff);
        queue_req(OP_INSERT, 32'h0000_0000);
        queue_req(OP_INSERT, 32'hffff_ffff);
        // duplicate insert
        queue_req(OP_INSERT, 32'h7fff_ffff);
        // remove from the middle, then the same value again
        queue_req(OP_INSERT, 32'h0000_0000);
        queue_req(OP_REMOVE, 32'h0000_0000);
        queue_req(OP_REMOVE, 32'h0000_0000);
        // fill to capacity
        for (int k = 1; k <= 13; k++)
            queue_req(OP_INSERT, k);
        // full set: present value and new value both rejected
        queue_req(OP_INSERT, 32'd5);
        queue_req(OP_INSERT, 32'd100);
        // remove first and last entries
        queue_req(OP_REMOVE, 32'h8000_0000);
        queue_req(OP_REMOVE, 32'd13);

        // random blocks alternate between growing and shrinking the set;
        // values mostly come from a small pool so hits are common
        for (int blk = 0; blk < 14; blk++) begin
            npool = $urandom_range(4, 24);
            for (int k = 0; k < 24; k++) begin
                case ($urandom_range(0, 7))
                    0: pool[k] = 32'h8000_0000 | $urandom_range(0, 3);
                    1: pool[k] = 32'h7fff_fffc | $urandom_range(0, 3);
                    2: pool[k] = $urandom_range(0, 7);
                    default: pool[k] = $urandom;
                endcase
            end
            ins_pct = (blk % 2 == 0) ? 72 : 28;
            for (int n = 0; n < 50; n++) begin
                op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
                v  = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, npool - 1)];
                queue_req(op, v, (n == 0) && (blk % 5 == 0));
            end
        end

        while (req_q.size() != 0 || i_in_valid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("bounded_unique_set_core_test: PASS");
        end else begin
            $display("bounded_unique_set_core_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bus_pkg.sv
hdl/bus_datapath.sv
hdl/bus_ctrl.sv
hdl/bounded_unique_set_core.sv
hdl/bus_checker.sv
bench/bounded_unique_set_core_test.sv
